### design/gclu_pkg.sv
// Package with shared widths, types and the sequencer states of the GCD/LCM unit.
`timescale 1ns / 1ps

package gclu_pkg;

  // Operand width; only the low VALUE_WIDTH bits of each operand are used.
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned ALU_W       = VALUE_WIDTH + 1;
  localparam int unsigned CNT_W       = $clog2(VALUE_WIDTH);

  // Port widths fixed by the interface.
  localparam int unsigned PORT_W      = 32;
  localparam int unsigned LCM_W       = 64;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SWAP,
    ST_QUOT,
    ST_MUL,
    ST_DONE
  } gclu_state_e;

  // Request to the shared adder/subtractor.
  typedef struct packed {
    logic [ALU_W-1:0] x;
    logic [ALU_W-1:0] y;
    logic             sub;
  } gclu_alu_req_t;

  // Response of the shared adder/subtractor.
  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             carry;
  } gclu_alu_rsp_t;

endpackage

### design/gcd_lcm_coprime_unit.sv
// Top level of the GCD, LCM and coprimality unit with its step sequencer.
`timescale 1ns / 1ps

// Computes gcd, lcm, a coprime flag and a zero-operand flag for two unsigned
// operands. Everything runs through one adder/subtractor: each Euclid
// remainder is a restoring division of VALUE_WIDTH steps plus a swap state,
// the quotient first/gcd takes another VALUE_WIDTH steps, and the product
// (first/gcd)*second is a shift-add over VALUE_WIDTH steps, followed by a
// done state that loads the output register once that register is free.
// An operand of zero skips the division and multiply and goes straight to
// the done state. One item is in work at a time; the result sits in an output
// register, so the next transaction is accepted while an earlier result still
// waits to be taken.
module gcd_lcm_coprime_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [gclu_pkg::PORT_W-1:0] first_value_i,
  input  logic [gclu_pkg::PORT_W-1:0] second_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [gclu_pkg::PORT_W-1:0] gcd_out_o,
  output logic [gclu_pkg::LCM_W-1:0]  lcm_out_o,
  output logic                       is_coprime_o,
  output logic                       zero_operand_o
);
  import gclu_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

  gclu_state_e state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] op_a_q, op_a_d;
  logic [VALUE_WIDTH-1:0] op_b_q, op_b_d;
  logic [VALUE_WIDTH-1:0] div_q, div_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [VALUE_WIDTH-1:0] hi_q, hi_d;
  logic [VALUE_WIDTH-1:0] gcd_q, gcd_d;
  logic                   zero_q, zero_d;

  logic                   out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0] out_gcd_q, out_gcd_d;
  logic [2*VALUE_WIDTH-1:0] out_lcm_q, out_lcm_d;
  logic                   out_zero_q, out_zero_d;

  gclu_alu_req_t alu_req;
  gclu_alu_rsp_t alu_rsp;

  logic [VALUE_WIDTH-1:0] in_a, in_b;
  logic [ALU_W-1:0]       rem_sh;
  logic [VALUE_WIDTH-1:0] step_rem;
  logic [VALUE_WIDTH-1:0] step_quo;
  logic                   in_fire;
  logic                   out_free;

  assign in_a       = first_value_i[VALUE_WIDTH-1:0];
  assign in_b       = second_value_i[VALUE_WIDTH-1:0];
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Restoring division step: shift the next dividend bit into the remainder.
  assign rem_sh   = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign step_rem = alu_rsp.carry ? alu_rsp.sum[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
  assign step_quo = {quo_q[VALUE_WIDTH-2:0], alu_rsp.carry};

  // Shared adder/subtractor.
  gclu_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Operand selection for the shared unit.
  always_comb begin
    if (state_q == ST_MUL) begin
      alu_req.x   = {1'b0, hi_q};
      alu_req.y   = quo_q[0] ? {1'b0, op_b_q} : '0;
      alu_req.sub = 1'b0;
    end else begin
      alu_req.x   = rem_sh;
      alu_req.y   = {1'b0, div_q};
      alu_req.sub = 1'b1;
    end
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    op_a_q     <= op_a_d;
    op_b_q     <= op_b_d;
    div_q      <= div_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    hi_q       <= hi_d;
    gcd_q      <= gcd_d;
    zero_q     <= zero_d;
    out_gcd_q  <= out_gcd_d;
    out_lcm_q  <= out_lcm_d;
    out_zero_q <= out_zero_d;
  end

  // Sequencer: next state and datapath control.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    op_a_d      = op_a_q;
    op_b_d      = op_b_q;
    div_d       = div_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    hi_d        = hi_q;
    gcd_d       = gcd_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_gcd_d   = out_gcd_q;
    out_lcm_d   = out_lcm_q;
    out_zero_d  = out_zero_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_a_d = in_a;
          op_b_d = in_b;
          if ((in_a == '0) || (in_b == '0)) begin
            // One operand zero: the gcd is the other one and the lcm is zero.
            gcd_d   = in_a | in_b;
            zero_d  = 1'b1;
            hi_d    = '0;
            quo_d   = '0;
            state_d = ST_DONE;
          end else begin
            zero_d  = 1'b0;
            div_d   = in_b;
            quo_d   = in_a;
            rem_d   = '0;
            cnt_d   = CNT_LAST;
            state_d = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        rem_d = step_rem;
        quo_d = step_quo;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_SWAP;
        end
      end

      ST_SWAP: begin
        // Euclid: the divisor becomes the dividend and the remainder the divisor.
        cnt_d = CNT_LAST;
        if (rem_q == '0) begin
          gcd_d   = div_q;
          quo_d   = op_a_q;
          state_d = ST_QUOT;
        end else begin
          quo_d   = div_q;
          div_d   = rem_q;
          state_d = ST_DIV;
        end
        rem_d = '0;
      end

      ST_QUOT: begin
        // Divide the first operand by the gcd, then start the multiply.
        rem_d = step_rem;
        quo_d = step_quo;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          hi_d    = '0;
          cnt_d   = CNT_LAST;
          state_d = ST_MUL;
        end
      end

      ST_MUL: begin
        // Shift-add multiply of the quotient by the second operand.
        hi_d  = alu_rsp.sum[VALUE_WIDTH:1];
        quo_d = {alu_rsp.sum[0], quo_q[VALUE_WIDTH-1:1]};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_gcd_d   = gcd_q;
          out_lcm_d   = {hi_q, quo_q};
          out_zero_d  = zero_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result ports.
  assign out_valid_o    = out_valid_q;
  assign gcd_out_o      = PORT_W'(out_gcd_q);
  assign lcm_out_o      = LCM_W'(out_lcm_q);
  assign is_coprime_o   = (out_gcd_q == VALUE_WIDTH'(1));
  assign zero_operand_o = out_zero_q;

endmodule

### design/gclu_alu.sv
// Shared adder/subtractor used for every division and multiplication step.
`timescale 1ns / 1ps

module gclu_alu (
  input  gclu_pkg::gclu_alu_req_t req_i,
  output gclu_pkg::gclu_alu_rsp_t rsp_o
);
  import gclu_pkg::*;

  logic [ALU_W-1:0] y_op;
  logic [ALU_W:0]   total;

  // On subtract, carry out high means x is not below y.
  assign y_op  = req_i.sub ? ~req_i.y : req_i.y;
  assign total = {1'b0, req_i.x} + {1'b0, y_op} + {{ALU_W{1'b0}}, req_i.sub};

  assign rsp_o.sum   = total[ALU_W-1:0];
  assign rsp_o.carry = total[ALU_W];

endmodule

### tb/gcd_lcm_coprime_unit_tb.sv
// Self-checking testbench for the GCD, LCM and coprimality unit.
`timescale 1ns / 1ps

module gcd_lcm_coprime_unit_tb;

  localparam int unsigned W           = gclu_pkg::PORT_W;
  localparam int unsigned LW          = gclu_pkg::LCM_W;
  localparam int unsigned RANDOM_OPS  = 528;
  localparam int unsigned QUIET_TAIL  = 80;
  localparam int unsigned DRAIN_AT    = 300;
  localparam int unsigned SETTLE_CYC  = 2000;
  localparam longint unsigned CYCLE_LIMIT = 64'd4_000_000;
  localparam logic [W-1:0] ALL_ONES   = '1;
  localparam logic [W-1:0] FIB_46     = 32'd1836311903;
  localparam logic [W-1:0] FIB_47     = 32'd2971215073;
  localparam logic [W-1:0] PRIME_A    = 32'd4294967291;
  localparam logic [W-1:0] PRIME_B    = 32'd4294967279;

  // Operand pattern families used by the random part.
  typedef enum int unsigned {
    PAT_FULL,
    PAT_SHARED,
    PAT_NARROW,
    PAT_TINY,
    PAT_MULTIPLE,
    PAT_NEIGHBOR
  } operand_pattern_e;

  // One expected result transaction.
  typedef struct {
    logic [W-1:0]  gcd;
    logic [LW-1:0] lcm;
    logic          coprime;
    logic          zero;
  } divisor_result_t;

  // Predicts each result from the accepted operands and checks results in order.
  class divisor_scoreboard;
    divisor_result_t expected_q[$];
    int unsigned     mismatches;
    int unsigned     checked;
    int unsigned     coprime_seen;
    int unsigned     zero_seen;

    function void note_operands(logic [W-1:0] first, logic [W-1:0] second);
      logic [63:0]     width_mask;
      logic [W-1:0]    x;
      logic [W-1:0]    y;
      logic [W-1:0]    rem;
      logic [W-1:0]    a;
      logic [W-1:0]    b;
      divisor_result_t exp_res;
      // Only the low VALUE_WIDTH bits of each operand take part.
      width_mask = (64'd1 << gclu_pkg::VALUE_WIDTH) - 64'd1;
      a = first & width_mask[W-1:0];
      b = second & width_mask[W-1:0];
      // Euclid's remainder loop.
      x = a;
      y = b;
      while (y != '0) begin
        rem = x % y;
        x = y;
        y = rem;
      end
      exp_res.gcd     = x;
      exp_res.zero    = (a == '0) || (b == '0);
      exp_res.lcm     = exp_res.zero ? '0 : LW'(a / x) * LW'(b);
      exp_res.coprime = (x == W'(1));
      expected_q.push_back(exp_res);
    endfunction

    function void check_result(logic [W-1:0] gcd, logic [LW-1:0] lcm, logic coprime,
                               logic zero);
      divisor_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result with no pending transaction: gcd_out %0d lcm_out %0d", gcd, lcm);
        mismatches++;
        return;
      end
      exp_res = expected_q.pop_front();
      checked++;
      if (exp_res.coprime) coprime_seen++;
      if (exp_res.zero) zero_seen++;
      if (gcd !== exp_res.gcd) begin
        $error("gcd_out: expected %0d, actual %0d", exp_res.gcd, gcd);
        mismatches++;
      end
      if (lcm !== exp_res.lcm) begin
        $error("lcm_out: expected %0d, actual %0d", exp_res.lcm, lcm);
        mismatches++;
      end
      if (coprime !== exp_res.coprime) begin
        $error("is_coprime: expected %0b, actual %0b", exp_res.coprime, coprime);
        mismatches++;
      end
      if (zero !== exp_res.zero) begin
        $error("zero_operand: expected %0b, actual %0b", exp_res.zero, zero);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic           clk_i          = 1'b0;
  logic           rst_ni         = 1'b0;
  logic           in_valid_i     = 1'b0;
  logic           in_stall_o;
  logic [W-1:0]   first_value_i  = '0;
  logic [W-1:0]   second_value_i = '0;
  logic           out_valid_o;
  logic           out_stall_i    = 1'b0;
  logic [W-1:0]   gcd_out_o;
  logic [LW-1:0]  lcm_out_o;
  logic           is_coprime_o;
  logic           zero_operand_o;

  divisor_scoreboard board = new();
  bit              quiet_tail  = 1'b0;
  int unsigned     idle_level  = 0;
  int unsigned     accepted    = 0;
  longint unsigned cycle_count = 0;
  int unsigned     stall_left  = 0;
  int unsigned     open_left   = 0;

  gcd_lcm_coprime_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .gcd_out_o      (gcd_out_o),
    .lcm_out_o      (lcm_out_o),
    .is_coprime_o   (is_coprime_o),
    .zero_operand_o (zero_operand_o)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Run time guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               board.outstanding());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Both handshakes are sampled with the values that the block saw at the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        board.note_operands(first_value_i, second_value_i);
        accepted++;
      end
      if (out_valid_o && !out_stall_i) begin
        board.check_result(gcd_out_o, lcm_out_o, is_coprime_o, zero_operand_o);
      end
    end
  end

  // Receiver back-pressure: random stall bursts between open stretches.
  always @(posedge clk_i) begin
    if (!rst_ni || quiet_tail) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (open_left != 0) begin
      out_stall_i <= 1'b0;
      open_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(0, 13);
    end else begin
      out_stall_i <= 1'b0;
      open_left = ($urandom_range(0, 5) == 0) ? $urandom_range(200, 1500)
                                              : $urandom_range(0, 60);
    end
  end

  // Presents one operand pair, with an optional idle burst first, and waits for acceptance.
  task automatic send_operands(input logic [W-1:0] first, input logic [W-1:0] second);
    int unsigned gap;
    if (!quiet_tail && $urandom_range(0, 3) < idle_level) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    first_value_i  <= first;
    second_value_i <= second;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // Holds the sender off until every pending result has been taken.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (board.outstanding() != 0);
    @(posedge clk_i);
  endtask

  initial begin
    logic [63:0]      directed_pairs [$];
    logic [W-1:0]     a;
    logic [W-1:0]     b;
    logic [W-1:0]     factor;
    logic [W-1:0]     swap_tmp;
    operand_pattern_e pattern;

    directed_pairs = '{
      {32'd0, 32'd0}, {32'd0, 32'd1}, {32'd1, 32'd0}, {32'd0, ALL_ONES},
      {ALL_ONES, 32'd0}, {32'd1, 32'd1}, {ALL_ONES, ALL_ONES}, {ALL_ONES, 32'd1},
      {32'd1, ALL_ONES}, {ALL_ONES, ALL_ONES - 32'd1}, {32'd12, 32'd18},
      {32'd18, 32'd12}, {32'd7, 32'd13}, {32'h8000_0000, 32'h8000_0000},
      {32'h8000_0000, 32'd6}, {FIB_46, FIB_47}, {FIB_47, FIB_46},
      {32'hFFFF_0000, 32'h0000_FFFF}, {32'hAAAA_AAAA, 32'h5555_5555},
      {PRIME_A, PRIME_B}, {32'd123456, 32'd123456}, {32'd5, 32'd0}
    };

    // Hold reset low, then release it.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corner cases: zeros, ones, all-ones, worst Euclid pair, large primes.
    idle_level = 1;
    foreach (directed_pairs[i]) send_operands(directed_pairs[i][63:32], directed_pairs[i][31:0]);
    wait_for_drain();

    // Random part with several operand families and varying idle density.
    for (int unsigned n = 0; n < RANDOM_OPS; n++) begin
      if (n % 50 == 0) idle_level = $urandom_range(0, 3);
      if (n == RANDOM_OPS - QUIET_TAIL) quiet_tail = 1'b1;
      if (n == DRAIN_AT) wait_for_drain();
      pattern = operand_pattern_e'($urandom_range(0, 5));
      case (pattern)
        PAT_FULL: begin
          a = $urandom();
          b = $urandom();
        end
        PAT_SHARED: begin
          factor = $urandom_range(2, 65535);
          a = factor * W'($urandom_range(1, ALL_ONES / factor));
          b = factor * W'($urandom_range(1, ALL_ONES / factor));
        end
        PAT_NARROW: begin
          a = $urandom() >> $urandom_range(0, 31);
          b = $urandom() >> $urandom_range(0, 31);
        end
        PAT_TINY: begin
          a = $urandom_range(0, 3);
          b = ($urandom_range(0, 1) == 0) ? W'($urandom_range(0, 3)) : W'($urandom());
        end
        PAT_MULTIPLE: begin
          b = $urandom_range(1, 65535);
          a = b * W'($urandom_range(1, ALL_ONES / b));
        end
        default: begin
          a = $urandom_range(1, ALL_ONES - 1);
          b = a + W'(1);
        end
      endcase
      if ($urandom_range(0, 1) == 1) begin
        swap_tmp = a;
        a = b;
        b = swap_tmp;
      end
      send_operands(a, b);
    end

    // Let the last results come out, then watch for stray ones.
    wait_for_drain();
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("Sent %0d operand pairs (directed corners plus random families); %0d checked.",
             accepted, board.checked);
    $display("Results covered %0d coprime pairs and %0d pairs with a zero operand; %0d mismatches.",
             board.coprime_seen, board.zero_seen, board.mismatches);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
